/* design/oust_pkg.sv */
package oust_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int VALUE_BITS  = 16;
    localparam int CMD_W       = 3;
    localparam int POS_W       = 6;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_FIND        = 3'd0,
        CMD_ADD         = 3'd1,
        CMD_REMOVE      = 3'd2,
        CMD_REMOVE_AT   = 3'd3,
        CMD_REMOVE_PERM = 3'd4,
        CMD_REPLACE     = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } state_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic   load;
        logic   shift;
        logic   apply;
        value_t val;
        value_t rep;
        cnt_t   count;
        logic   drop_en;
        idx_t   drop_pos;
        logic   write_en;
        idx_t   write_pos;
        value_t write_data;
        logic   dec_en;
    } cell_ctl_t;

    typedef struct packed {
        logic hv;
        logic hr;
    } cell_hit_t;

endpackage

/* design/ordered_unique_set_table_top.sv */
// Ordered set of unique item numbers with compaction on removal.
// Command channel: present cmd, item_value, replacement_value and position
// with start high; the transaction is taken on a clock edge where busy is low.
// Result channel: done pulses for one cycle with ok, found_position and
// entry_count valid in that same cycle; the receiver has no way to stall it.
// Storage is a chain of cells, one per entry. On acceptance every cell
// compares its entry against item_value and replacement_value at once; the
// hit flags then ripple toward cell 0 one position per cycle until every held
// entry has been seen there. The apply state then writes, shifts the tail
// down or decrements entries in every cell in parallel.
// busy drops in the cycle done is high, so the next command can be taken then.
// Reset clears the entry count and the control state; entry storage is not
// cleared and is only read below the count.
module ordered_unique_set_table_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [oust_pkg::CMD_W-1:0]    cmd,
    input  logic [oust_pkg::VALUE_BITS-1:0] item_value,
    input  logic [oust_pkg::VALUE_BITS-1:0] replacement_value,
    input  logic [oust_pkg::POS_W-1:0]    position,
    output logic                          busy,
    output logic                          done,
    output logic                          ok,
    output logic [oust_pkg::POS_W-1:0]    found_position,
    output logic [oust_pkg::CNT_W-1:0]    entry_count
);

    oust_pkg::cell_ctl_t ctl;
    oust_pkg::value_t    cell_value [oust_pkg::MAX_ENTRIES+1];
    oust_pkg::cell_hit_t cell_hit   [oust_pkg::MAX_ENTRIES+1];

    oust_ctrl u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .cmd               (cmd),
        .item_value        (item_value),
        .replacement_value (replacement_value),
        .position          (position),
        .busy              (busy),
        .done              (done),
        .ok                (ok),
        .found_position    (found_position),
        .entry_count       (entry_count),
        .ctl               (ctl),
        .head_hit          (cell_hit[0])
    );

    // past the last cell: nothing to pull in
    assign cell_value[oust_pkg::MAX_ENTRIES] = '0;
    assign cell_hit[oust_pkg::MAX_ENTRIES]   = '0;

    for (genvar i = 0; i < oust_pkg::MAX_ENTRIES; i++)
    begin : g_cell
        oust_cell u_cell (
            .clk        (clk),
            .idx        (oust_pkg::IDX_W'(i)),
            .ctl        (ctl),
            .next_value (cell_value[i+1]),
            .next_hit   (cell_hit[i+1]),
            .value      (cell_value[i]),
            .hit        (cell_hit[i])
        );
    end

endmodule

/* design/oust_cell.sv */
module oust_cell (
    input  logic                clk,
    input  oust_pkg::idx_t      idx,
    input  oust_pkg::cell_ctl_t ctl,
    input  oust_pkg::value_t    next_value,
    input  oust_pkg::cell_hit_t next_hit,
    output oust_pkg::value_t    value,
    output oust_pkg::cell_hit_t hit
);

    oust_pkg::value_t    value_reg;
    oust_pkg::value_t    value_next;
    oust_pkg::cell_hit_t hit_reg;
    oust_pkg::cell_hit_t hit_next;
    oust_pkg::value_t    src;
    logic                in_use;

    always_comb
    begin
        in_use = oust_pkg::CNT_W'(idx) < ctl.count;

        hit_next = hit_reg;
        if (ctl.load)
        begin
            hit_next.hv = in_use && (value_reg == ctl.val);
            hit_next.hr = in_use && (value_reg == ctl.rep);
        end
        else if (ctl.shift)
        begin
            hit_next = next_hit;
        end

        // close the gap: every cell at or above the dropped slot pulls from its neighbor
        src = value_reg;
        if (ctl.drop_en && (idx >= ctl.drop_pos))
            src = next_value;
        if (ctl.write_en && (idx == ctl.write_pos))
            src = ctl.write_data;
        if (ctl.dec_en && (src > ctl.val))
            src = src - oust_pkg::VALUE_BITS'(1);

        value_next = ctl.apply ? src : value_reg;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        hit_reg   <= hit_next;
    end

    assign value = value_reg;
    assign hit   = hit_reg;

endmodule

/* design/oust_ctrl.sv */
module oust_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [oust_pkg::CMD_W-1:0]    cmd,
    input  oust_pkg::value_t              item_value,
    input  oust_pkg::value_t              replacement_value,
    input  logic [oust_pkg::POS_W-1:0]    position,
    output logic                          busy,
    output logic                          done,
    output logic                          ok,
    output logic [oust_pkg::POS_W-1:0]    found_position,
    output logic [oust_pkg::CNT_W-1:0]    entry_count,
    output oust_pkg::cell_ctl_t           ctl,
    input  oust_pkg::cell_hit_t           head_hit
);

    oust_pkg::state_t state_reg, state_next;
    oust_pkg::cmd_t   cmd_reg, cmd_next;
    oust_pkg::value_t val_reg, val_next;
    oust_pkg::value_t rep_reg, rep_next;
    logic [oust_pkg::POS_W-1:0] position_reg, position_next;
    oust_pkg::cnt_t   count_reg, count_next;
    oust_pkg::cnt_t   scan_reg, scan_next;
    logic             hit_reg, hit_next;
    logic             rep_hit_reg, rep_hit_next;
    oust_pkg::idx_t   pos_reg, pos_next;
    logic             done_reg, done_next;
    logic             ok_reg, ok_next;
    logic [oust_pkg::POS_W-1:0] fpos_reg, fpos_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            oust_pkg::ST_IDLE:
                if (start)
                    state_next = oust_pkg::ST_SCAN;
            oust_pkg::ST_SCAN:
                if (scan_reg >= count_reg)
                    state_next = oust_pkg::ST_APPLY;
            oust_pkg::ST_APPLY:
                state_next = oust_pkg::ST_IDLE;
            default:
                state_next = oust_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_next      = cmd_reg;
        val_next      = val_reg;
        rep_next      = rep_reg;
        position_next = position_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        hit_next      = hit_reg;
        rep_hit_next  = rep_hit_reg;
        pos_next      = pos_reg;
        done_next     = 1'b0;
        ok_next       = ok_reg;
        fpos_next     = fpos_reg;

        ctl            = '0;
        ctl.val        = (state_reg == oust_pkg::ST_IDLE) ? item_value : val_reg;
        ctl.rep        = (state_reg == oust_pkg::ST_IDLE) ? replacement_value : rep_reg;
        ctl.count      = count_reg;
        ctl.write_data = val_reg;

        unique case (state_reg)
            oust_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load      = 1'b1;
                    cmd_next      = oust_pkg::cmd_t'(cmd);
                    val_next      = item_value;
                    rep_next      = replacement_value;
                    position_next = position;
                    scan_next     = '0;
                    hit_next      = 1'b0;
                    rep_hit_next  = 1'b0;
                    pos_next      = '0;
                end
            end
            oust_pkg::ST_SCAN:
            begin
                // walk the hit bits toward the head, one entry per cycle
                if (scan_reg < count_reg)
                begin
                    ctl.shift = 1'b1;
                    if (head_hit.hv)
                    begin
                        hit_next = 1'b1;
                        pos_next = scan_reg[oust_pkg::IDX_W-1:0];
                    end
                    if (head_hit.hr)
                        rep_hit_next = 1'b1;
                    scan_next = scan_reg + oust_pkg::CNT_W'(1);
                end
            end
            oust_pkg::ST_APPLY:
            begin
                ctl.apply = 1'b1;
                done_next = 1'b1;
                ok_next   = 1'b0;
                fpos_next = hit_reg ? oust_pkg::POS_W'(pos_reg) : '0;
                unique case (cmd_reg)
                    oust_pkg::CMD_FIND:
                        ok_next = hit_reg;
                    oust_pkg::CMD_ADD:
                    begin
                        if (!hit_reg && (count_reg < oust_pkg::CNT_W'(oust_pkg::MAX_ENTRIES)))
                        begin
                            ctl.write_en  = 1'b1;
                            ctl.write_pos = count_reg[oust_pkg::IDX_W-1:0];
                            count_next    = count_reg + oust_pkg::CNT_W'(1);
                            ok_next       = 1'b1;
                        end
                    end
                    oust_pkg::CMD_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            ctl.drop_en  = 1'b1;
                            ctl.drop_pos = pos_reg;
                            count_next   = count_reg - oust_pkg::CNT_W'(1);
                            ok_next      = 1'b1;
                        end
                    end
                    oust_pkg::CMD_REMOVE_AT:
                    begin
                        fpos_next = '0;
                        if (oust_pkg::CNT_W'(position_reg) < count_reg)
                        begin
                            ctl.drop_en  = 1'b1;
                            ctl.drop_pos = oust_pkg::IDX_W'(position_reg);
                            count_next   = count_reg - oust_pkg::CNT_W'(1);
                            ok_next      = 1'b1;
                        end
                    end
                    oust_pkg::CMD_REMOVE_PERM:
                    begin
                        ctl.dec_en = 1'b1;
                        if (hit_reg)
                        begin
                            ctl.drop_en  = 1'b1;
                            ctl.drop_pos = pos_reg;
                            count_next   = count_reg - oust_pkg::CNT_W'(1);
                            ok_next      = 1'b1;
                        end
                    end
                    oust_pkg::CMD_REPLACE:
                    begin
                        if (hit_reg)
                        begin
                            ok_next = 1'b1;
                            if (rep_hit_reg)
                            begin
                                ctl.drop_en  = 1'b1;
                                ctl.drop_pos = pos_reg;
                                count_next   = count_reg - oust_pkg::CNT_W'(1);
                            end
                            else
                            begin
                                ctl.write_en   = 1'b1;
                                ctl.write_pos  = pos_reg;
                                ctl.write_data = rep_reg;
                            end
                        end
                    end
                    default:
                        fpos_next = '0;
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= oust_pkg::ST_IDLE;
            count_reg   <= '0;
            scan_reg    <= '0;
            hit_reg     <= 1'b0;
            rep_hit_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            scan_reg    <= scan_next;
            hit_reg     <= hit_next;
            rep_hit_reg <= rep_hit_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        val_reg      <= val_next;
        rep_reg      <= rep_next;
        position_reg <= position_next;
        pos_reg      <= pos_next;
        ok_reg       <= ok_next;
        fpos_reg     <= fpos_next;
    end

    assign busy           = (state_reg != oust_pkg::ST_IDLE);
    assign done           = done_reg;
    assign ok             = ok_reg;
    assign found_position = fpos_reg;
    assign entry_count    = count_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= oust_pkg::CNT_W'(oust_pkg::MAX_ENTRIES))
        else $error("entry count above capacity");

    a_done_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == oust_pkg::ST_APPLY |=> done_reg && state_reg == oust_pkg::ST_IDLE)
        else $error("result strobe missing after apply");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != oust_pkg::ST_APPLY |=> count_reg == $past(count_reg))
        else $error("entry count moved outside apply");

    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == oust_pkg::ST_APPLY && hit_reg |-> oust_pkg::CNT_W'(pos_reg) < count_reg)
        else $error("found position beyond held entries");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == oust_pkg::ST_SCAN |-> scan_reg <= count_reg)
        else $error("scan ran past held entries");

endmodule
